>>> rtl/wrg_pkg.sv
`default_nettype none
package wrg_pkg;

    localparam int SIDE_BITS  = 6;
    localparam int ADDR_W     = 2 * SIDE_BITS;
    localparam int VALUE_BITS = 16;
    localparam int AVG_SHIFT  = 1;

    localparam logic [SIDE_BITS-1:0] GRID_DIVS = 6'd63;
    localparam logic [SIDE_BITS-1:0] LAST_IN   = 6'd62;
    localparam logic [SIDE_BITS-1:0] FIRST_IN  = 6'd1;

    typedef enum logic [1:0] {
        FUNC_IMPULSE = 2'd0,
        FUNC_STEP    = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        REG_DAMPING     = 4'd0,
        REG_VALUE_MIN   = 4'd1,
        REG_VALUE_MAX   = 4'd2,
        REG_IMPULSE_CAP = 4'd3,
        REG_EDGE_TOP    = 4'd4,
        REG_EDGE_LEFT   = 4'd5,
        REG_EDGE_RIGHT  = 4'd6,
        REG_EDGE_BOTTOM = 4'd7
    } t_reg;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b0_0000_0001,
        S_IDLE    = 9'b0_0000_0010,
        S_IMP_RD  = 9'b0_0000_0100,
        S_IMP_WR  = 9'b0_0000_1000,
        S_RD_RD   = 9'b0_0001_0000,
        S_RD_DATA = 9'b0_0010_0000,
        S_BORDER  = 9'b0_0100_0000,
        S_CELL    = 9'b0_1000_0000,
        S_DONE    = 9'b1_0000_0000
    } t_state;

    // clamp to [lo, hi]; inverted bounds give hi
    function automatic logic signed [20:0] clamp21(
        input logic signed [20:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [20:0] r;
        r = v;
        if (r < 21'(lo)) r = 21'(lo);
        if (r > 21'(hi)) r = 21'(hi);
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/water_ripple_grid_step.sv
// water ripple height-field engine, 64 x 64 cells of signed Q4.11
//
// input stream (i_s_*): one transfer per command, tuser holds func
//   (0 impulse, 1 step, 2 read, 3 no-op); tdata holds cell_x, cell_z and
//   impulse_amount. every command yields exactly one result transfer on
//   o_m_* (tdata height_value, tuser accepted).
// config port (i_cfg_*): register index and data, always ready; write only
//   while no command is in flight.
// a step makes 256 border writes, then updates the interior cells (62 x 62
//   cells) one after another; the single read port of the current grid,
//   fetching the four neighbours one after another through a shared adder,
//   sets its length.
// one command is worked at a time; o_s_tready is low while busy.
// reset: both grids are cleared by a pass over all 4096 addresses, one
//   address per cycle in both grids; no command is taken until it ends.
// a stalled receiver holds the result in the output register; the next
//   command is still taken, but its result waits until the register frees.
`default_nettype none
module water_ripple_grid_step
    import wrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // cell_x[5:0], cell_z[11:6], impulse_amount[27:12]
    input  wire logic [1:0]  i_s_tuser,   // func[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // height_value[15:0]
    output logic             o_m_tuser,   // accepted[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0]        r_damping;
    logic signed [15:0] r_vmin, r_vmax;
    logic [14:0]        r_cap;
    logic signed [15:0] r_etop, r_eleft, r_eright, r_ebottom;

    t_state r_state;
    logic   r_bank;             // 0: grid a holds current heights
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_addr;
    logic signed [15:0] r_amt;
    logic [SIDE_BITS-1:0] r_bt;  // border sweep position
    logic [1:0]           r_bs;  // which border edge
    logic [SIDE_BITS-1:0] r_row, r_col;
    logic [2:0]           r_ph;
    logic signed [17:0] r_acc;
    logic signed [15:0] r_prev;
    logic signed [17:0] r_diff;
    logic signed [34:0] r_prod;
    logic signed [15:0] r_res_h;
    logic               r_res_ok;
    logic               r_out_valid;
    logic [15:0]        r_out_h;
    logic               r_out_ok;

    // two physical grids
    logic signed [15:0] mem_a [1 << ADDR_W];
    logic signed [15:0] mem_b [1 << ADDR_W];
    logic signed [15:0] r_qa, r_qb;

    logic [ADDR_W-1:0]  cur_raddr, prv_raddr, cur_waddr, prv_waddr;
    logic               cur_we, prv_we;
    logic signed [15:0] cur_wdata, prv_wdata, cur_q, prv_q;
    logic [ADDR_W-1:0]  ra_a, ra_b, wa_a, wa_b;
    logic               we_a, we_b;
    logic signed [15:0] wd_a, wd_b;

    // border cell address and value
    logic [ADDR_W-1:0]    bd_addr;
    logic signed [15:0]   bd_val;
    logic [SIDE_BITS-1:0] bd_x, bd_z;

    // arithmetic of the shared datapath
    logic signed [17:0] add_b;
    logic signed [17:0] acc_sum;
    logic signed [20:0] prev_cl;
    logic signed [35:0] rnd;
    logic signed [20:0] new_cl;
    logic signed [16:0] amt_cl, cap_s;
    logic signed [17:0] imp_sum;
    logic signed [15:0] imp_val;

    logic s_acc;
    logic [SIDE_BITS-1:0] in_x, in_z;
    t_func in_func;

    assign in_x    = i_s_tdata[5:0];
    assign in_z    = i_s_tdata[11:6];
    assign in_func = t_func'(i_s_tuser);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_h;
    assign o_m_tuser   = r_out_ok;
    assign s_acc       = i_s_tvalid && o_s_tready;

    // role to bank mapping
    assign ra_a  = r_bank ? prv_raddr : cur_raddr;
    assign ra_b  = r_bank ? cur_raddr : prv_raddr;
    assign we_a  = r_bank ? prv_we : cur_we;
    assign we_b  = r_bank ? cur_we : prv_we;
    assign wa_a  = r_bank ? prv_waddr : cur_waddr;
    assign wa_b  = r_bank ? cur_waddr : prv_waddr;
    assign wd_a  = r_bank ? prv_wdata : cur_wdata;
    assign wd_b  = r_bank ? cur_wdata : prv_wdata;
    assign cur_q = r_bank ? r_qb : r_qa;
    assign prv_q = r_bank ? r_qa : r_qb;

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_a] <= wd_a;
        end
        r_qa <= mem_a[ra_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[wa_b] <= wd_b;
        end
        r_qb <= mem_b[ra_b];
    end

    // border sweep: top, left, right, bottom per position; corners resolved
    // so that left wins at both left corners, top at top-right, bottom at
    // bottom-right
    always_comb begin
        case (r_bs)
            2'd0:    bd_addr = {{SIDE_BITS{1'b0}}, r_bt};
            2'd1:    bd_addr = {r_bt, {SIDE_BITS{1'b0}}};
            2'd2:    bd_addr = {r_bt, GRID_DIVS};
            default: bd_addr = {GRID_DIVS, r_bt};
        endcase
        bd_z = bd_addr[ADDR_W-1:SIDE_BITS];
        bd_x = bd_addr[SIDE_BITS-1:0];
        if (bd_x == '0) begin
            bd_val = r_eleft;
        end else if (bd_z == '0) begin
            bd_val = r_etop;
        end else if (bd_z == GRID_DIVS) begin
            bd_val = r_ebottom;
        end else begin
            bd_val = r_eright;
        end
    end

    // neighbour fetch order: up, left, right, down
    always_comb begin
        cur_raddr = r_addr;
        prv_raddr = r_addr;
        if (r_state == S_CELL) begin
            prv_raddr = {r_row, r_col};
            case (r_ph)
                3'd0:    cur_raddr = {r_row - 6'd1, r_col};
                3'd1:    cur_raddr = {r_row, r_col - 6'd1};
                3'd2:    cur_raddr = {r_row, r_col + 6'd1};
                3'd3:    cur_raddr = {r_row + 6'd1, r_col};
                default: cur_raddr = {r_row, r_col};
            endcase
        end
    end

    // datapath
    always_comb begin
        add_b   = {{2{cur_q[15]}}, cur_q};
        acc_sum = r_acc + add_b;
        prev_cl = clamp21({{5{r_prev[15]}}, r_prev}, r_vmin, r_vmax);
        rnd     = {r_prod[34], r_prod} + 36'sd16384;
        new_cl  = clamp21(rnd[35:15], r_vmin, r_vmax);
        cap_s   = {2'b00, r_cap};
        amt_cl  = {r_amt[15], r_amt};
        if (amt_cl > cap_s) amt_cl = cap_s;
        if (amt_cl < -cap_s) amt_cl = -cap_s;
        imp_sum = {{2{prv_q[15]}}, prv_q} + {amt_cl[16], amt_cl};
        if (imp_sum > 18'sd32767) begin
            imp_val = 16'sh7FFF;
        end else if (imp_sum < -18'sd32768) begin
            imp_val = 16'sh8000;
        end else begin
            imp_val = imp_sum[15:0];
        end
    end

    // write ports
    always_comb begin
        cur_we    = 1'b0;
        cur_waddr = bd_addr;
        cur_wdata = bd_val;
        prv_we    = 1'b0;
        prv_waddr = r_addr;
        prv_wdata = imp_val;
        case (r_state)
            S_CLEAR: begin
                cur_we    = 1'b1;
                cur_waddr = r_clr;
                cur_wdata = '0;
                prv_we    = 1'b1;
                prv_waddr = r_clr;
                prv_wdata = '0;
            end
            S_BORDER: begin
                cur_we = 1'b1;
            end
            S_IMP_WR: begin
                prv_we = 1'b1;
            end
            S_CELL: begin
                prv_we    = (r_ph == 3'd7);
                prv_waddr = {r_row, r_col};
                prv_wdata = new_cl[15:0];
            end
            default: begin
                cur_we = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= 16'd32440;
            r_vmin    <= 16'sh8000;
            r_vmax    <= 16'sh7FFF;
            r_cap     <= 15'd2048;
            r_etop    <= '0;
            r_eleft   <= '0;
            r_eright  <= '0;
            r_ebottom <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_DAMPING:     r_damping <= i_cfg_data;
                REG_VALUE_MIN:   r_vmin    <= i_cfg_data;
                REG_VALUE_MAX:   r_vmax    <= i_cfg_data;
                REG_IMPULSE_CAP: r_cap     <= i_cfg_data[14:0];
                REG_EDGE_TOP:    r_etop    <= i_cfg_data;
                REG_EDGE_LEFT:   r_eleft   <= i_cfg_data;
                REG_EDGE_RIGHT:  r_eright  <= i_cfg_data;
                REG_EDGE_BOTTOM: r_ebottom <= i_cfg_data;
                default:         r_etop    <= r_etop;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_bank      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_addr   <= {in_z, in_x};
                        r_amt    <= i_s_tdata[27:12];
                        r_res_h  <= '0;
                        r_res_ok <= 1'b0;
                        r_bt     <= '0;
                        r_bs     <= '0;
                        case (in_func)
                            FUNC_IMPULSE: begin
                                if (in_x >= FIRST_IN && in_x <= LAST_IN &&
                                    in_z >= FIRST_IN && in_z <= LAST_IN) begin
                                    r_state <= S_IMP_RD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            FUNC_STEP: r_state <= S_BORDER;
                            FUNC_READ: r_state <= S_RD_RD;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_IMP_RD: r_state <= S_IMP_WR;
                S_IMP_WR: begin
                    r_res_ok <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_RD_RD: r_state <= S_RD_DATA;
                S_RD_DATA: begin
                    r_res_h  <= cur_q;
                    r_res_ok <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_BORDER: begin
                    r_bs <= r_bs + 2'd1;
                    if (r_bs == 2'd3) begin
                        r_bt <= r_bt + 6'd1;
                        if (r_bt == GRID_DIVS) begin
                            r_row   <= FIRST_IN;
                            r_col   <= FIRST_IN;
                            r_ph    <= '0;
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    r_ph <= r_ph + 3'd1;
                    case (r_ph)
                        3'd1: begin
                            r_acc  <= add_b;
                            r_prev <= prv_q;
                        end
                        3'd2, 3'd3, 3'd4: r_acc <= acc_sum;
                        3'd5: r_diff <= (r_acc >>> AVG_SHIFT) - $signed(prev_cl[17:0]);
                        3'd6: r_prod <= r_diff * $signed({1'b0, r_damping});
                        3'd7: begin
                            if (r_col == LAST_IN) begin
                                r_col <= FIRST_IN;
                                if (r_row == LAST_IN) begin
                                    r_bank   <= ~r_bank;
                                    r_res_ok <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_row <= r_row + 6'd1;
                                end
                            end else begin
                                r_col <= r_col + 6'd1;
                            end
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_h  <= r_res_h;
                        r_out_ok <= r_res_ok;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("command taken during grid clear");

    a_cell_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_row != '0 && r_row != GRID_DIVS &&
                                 r_col != '0 && r_col != GRID_DIVS))
        else $error("update sweep left the interior");

    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_bank) |-> $past(r_state == S_CELL))
        else $error("grids swapped outside a step");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result transfer without finished command");

endmodule
`default_nettype wire

>>> tb/tb_water_ripple_grid_step.sv
`default_nettype none
module tb_water_ripple_grid_step;
    import wrg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE      = 64;
    localparam int CELLS     = SIDE * SIDE;
    localparam int LIMIT     = 3_000_000;   // run-away bound, far above the run time of all steps the test can issue
    localparam int MAX_STEPS = 14;          // random steps, each sweeps the whole grid
    localparam int HOLD_LONG = 400;

    typedef struct packed {
        logic [15:0] height;
        logic        ok;
    } t_result;

    // ripple predictor plus the queue of results still owed by the block
    class ripple_scoreboard;
        int           grid [2][CELLS];
        bit           bank;
        logic [15:0]  damping;
        logic signed [15:0] vmin, vmax, e_top, e_left, e_right, e_bottom;
        logic [14:0]  cap;
        t_result      owed [$];
        int           errs, seen;
        int           n_func [4];

        function new();
            foreach (grid[b, k]) grid[b][k] = 0;
            bank = 0;
            damping = 16'd32440; vmin = -16'sd32768; vmax = 16'sd32767; cap = 15'd2048;
            e_top = 0; e_left = 0; e_right = 0; e_bottom = 0;
            errs = 0; seen = 0;
            foreach (n_func[i]) n_func[i] = 0;
        endfunction

        function void set_reg(t_reg idx, logic [15:0] d);
            case (idx)
                REG_DAMPING:     damping = d;
                REG_VALUE_MIN:   vmin = d;
                REG_VALUE_MAX:   vmax = d;
                REG_IMPULSE_CAP: cap = d[14:0];
                REG_EDGE_TOP:    e_top = d;
                REG_EDGE_LEFT:   e_left = d;
                REG_EDGE_RIGHT:  e_right = d;
                REG_EDGE_BOTTOM: e_bottom = d;
                default: ;
            endcase
        endfunction

        function longint sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // inverted bounds end on the upper bound
        function longint clamp_cfg(longint v);
            if (v < longint'(vmin)) v = vmin;
            if (v > longint'(vmax)) v = vmax;
            return v;
        endfunction

        function void ripple_step();
            int cur, prv, k;
            longint sum, diff, prod;
            cur = bank;
            prv = !bank;
            // later writes win at the corners, as in the sweep order of the borders
            for (int t = 0; t < SIDE; t++) begin
                grid[cur][t]                  = e_top;
                grid[cur][t * SIDE]           = e_left;
                grid[cur][(t + 1) * SIDE - 1] = e_right;
                grid[cur][(SIDE - 1) * SIDE + t] = e_bottom;
            end
            for (int i = 1; i < SIDE - 1; i++)
                for (int j = 1; j < SIDE - 1; j++) begin
                    k = i * SIDE + j;
                    sum = longint'(grid[cur][k + SIDE]) + grid[cur][k - SIDE]
                        + grid[cur][k + 1] + grid[cur][k - 1];
                    diff = (sum >>> AVG_SHIFT) - clamp_cfg(grid[prv][k]);
                    prod = diff * longint'(damping);
                    grid[prv][k] = int'(sat16(clamp_cfg((prod + 16384) >>> 15)));
                end
            bank = !bank;
        endfunction

        // note an accepted command and work out what it must return
        function void note_command(t_func f, int x, int z, logic signed [15:0] amt);
            t_result r;
            longint a;
            r = '0;
            n_func[f]++;
            case (f)
                FUNC_IMPULSE:
                    if (x >= 1 && x <= 62 && z >= 1 && z <= 62) begin
                        a = amt;
                        if (a > longint'(cap)) a = cap;
                        if (a < -longint'(cap)) a = -longint'(cap);
                        grid[!bank][z * SIDE + x] = int'(sat16(grid[!bank][z * SIDE + x] + a));
                        r.ok = 1'b1;
                    end
                FUNC_STEP: begin
                    ripple_step();
                    r.ok = 1'b1;
                end
                FUNC_READ: begin
                    r.height = grid[bank][z * SIDE + x][15:0];
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            owed = {owed, r};
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errs++;
            $display("mismatch #%0d at %0t: %s got 0x%04h want 0x%04h",
                     seen, $time, what, got, want);
        endtask

        task check_result(logic [15:0] height, logic ok);
            t_result w;
            seen++;
            if (owed.size() == 0) begin
                report("unexpected transfer", height, 16'h0);
                return;
            end
            w = owed.pop_front();
            if (height !== w.height) report("height_value", height, w.height);
            if (ok !== w.ok) report("accepted", {15'd0, ok}, {15'd0, w.ok});
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    logic [15:0] o_m_tdata;

    water_ripple_grid_step u_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    ripple_scoreboard sb = new();

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run-away guard
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** water_ripple_grid_step: FAILED **");
            $finish;
        end
    end

    // result side: checks each transfer, then picks its own stall pattern
    logic hold_req = 1'b0;   // main flips it to ask for one long hold-off
    logic hold_ack = 1'b0;
    bit   calm = 0;          // stretches where the receiver never stalls
    int   rx_wait = 0;
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tuser);
            rx_wait = calm ? 0 : $urandom_range(0, 18);
        end
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            rx_wait = HOLD_LONG;
        end
        if (rx_wait > 0) begin
            rx_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // one command transfer; valid stays high into the next when there is no gap
    task send_cmd(t_func f, int x, int z, logic [15:0] amt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {4'd0, amt, z[5:0], x[5:0]};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(f, x, z, amt);
    endtask

    task drain();
        i_s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);   // block back in idle
    endtask

    // writes all eight registers back to back
    task write_regs(logic [15:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 4'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(t_reg'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_cmds(int n, ref int steps_left);
        int r, x, z;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8 && steps_left > 0) begin
                steps_left--;
                send_cmd(FUNC_STEP, 0, 0, 16'($urandom));
            end else if (r < 50) begin
                // mostly interior cells, some anywhere
                if ($urandom_range(0, 4) == 0) begin
                    x = $urandom_range(0, 63); z = $urandom_range(0, 63);
                end else begin
                    x = $urandom_range(1, 62); z = $urandom_range(1, 62);
                end
                send_cmd(FUNC_IMPULSE, x, z, 16'($urandom));
            end else if (r < 92) begin
                send_cmd(FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                         16'($urandom));
            end else begin
                send_cmd(FUNC_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                         16'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] cfg [8];
        int steps_left;
        steps_left = MAX_STEPS;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 0: full damping, widest bounds, cap at its top
        cfg = '{16'd32768, 16'h8000, 16'h7FFF, 16'h7FFF,
                16'h7FFF, 16'h8000, 16'd1234, 16'hFEDC};
        write_regs(cfg);
        calm = 1;
        send_cmd(FUNC_READ, 0, 0, 16'h0);
        send_cmd(FUNC_READ, 63, 63, 16'hFFFF);
        send_cmd(FUNC_IMPULSE, 0, 5, 16'h0100);     // border column: dropped
        send_cmd(FUNC_IMPULSE, 63, 5, 16'h0100);
        send_cmd(FUNC_IMPULSE, 5, 0, 16'h0100);
        send_cmd(FUNC_IMPULSE, 5, 63, 16'h0100);
        send_cmd(FUNC_IMPULSE, 1, 1, 16'h7FFF);
        send_cmd(FUNC_IMPULSE, 1, 1, 16'h7FFF);     // saturates high
        send_cmd(FUNC_IMPULSE, 62, 62, 16'h8000);
        send_cmd(FUNC_IMPULSE, 62, 62, 16'h8000);   // saturates low
        send_cmd(FUNC_IMPULSE, 30, 40, 16'h0ABC);
        send_cmd(FUNC_NOP, 30, 40, 16'h1234);
        calm = 0;
        send_cmd(FUNC_STEP, 0, 0, 16'h0);
        send_cmd(FUNC_READ, 0, 0, 16'h0);           // corners
        send_cmd(FUNC_READ, 63, 0, 16'h0);
        send_cmd(FUNC_READ, 0, 63, 16'h0);
        send_cmd(FUNC_READ, 63, 63, 16'h0);
        send_cmd(FUNC_READ, 1, 1, 16'h0);
        send_cmd(FUNC_STEP, 0, 0, 16'h0);
        send_cmd(FUNC_READ, 2, 1, 16'h0);
        send_cmd(FUNC_READ, 30, 39, 16'h0);
        send_cmd(FUNC_READ, 62, 61, 16'h0);
        random_cmds(20, steps_left);
        drain();

        // phase 1: no damping, inverted bounds, zero cap, long output stall
        cfg = '{16'd0, 16'd100, 16'hFF9C, 16'd0,
                16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        write_regs(cfg);
        hold_req <= ~hold_req;
        random_cmds(30, steps_left);
        drain();

        // phase 2: random settings, pause for an empty pipe midway
        for (int i = 0; i < 8; i++) cfg[i] = 16'($urandom);
        cfg[0] = 16'($urandom_range(0, 32768));
        cfg[1] = 16'($urandom_range(0, 2000)) - 16'd2000;
        cfg[2] = 16'($urandom_range(0, 4000));
        cfg[3] = 16'($urandom_range(0, 32767));
        write_regs(cfg);
        random_cmds(15, steps_left);
        drain();
        calm = 1'($urandom_range(0, 1));
        random_cmds(20, steps_left);
        calm = 0;
        drain();

        // phase 3: defaults again
        cfg = '{16'd32440, 16'h8000, 16'h7FFF, 16'd2048, 16'd0, 16'd0, 16'd0, 16'd0};
        write_regs(cfg);
        random_cmds(30, steps_left);
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d impulses, %0d steps, %0d reads, %0d no-ops over four settings",
                 sb.n_func[FUNC_IMPULSE], sb.n_func[FUNC_STEP], sb.n_func[FUNC_READ],
                 sb.n_func[FUNC_NOP]);
        $display("%0d results checked, %0d mismatches, %0d cycles", sb.seen, sb.errs, cycles);
        if (sb.errs == 0 && sb.owed.size() == 0)
            $display("** water_ripple_grid_step: PASSED **");
        else
            $display("** water_ripple_grid_step: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
